[design/vlsag_pkg.sv]
// vlsag_pkg: types and constants shared by the vector load/store address generator.
// Holds instruction field codes, configuration register indexes and pipeline structs.
// No dependencies.
`default_nettype none

package vlsag_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [1:0] CFG_ELEMENT_WIDTH = 2'd1;
    localparam logic [1:0] CFG_GROUP_MULT    = 2'd2;
    localparam logic [1:0] CFG_REGISTER_BYTES = 2'd3;

    // mop field codes
    localparam logic [1:0] MOP_UNIT    = 2'd0;
    localparam logic [1:0] MOP_STRIDED = 2'd2;

    // lumop field codes for unit-stride forms
    localparam logic [4:0] LUMOP_PLAIN  = 5'd0;
    localparam logic [4:0] LUMOP_WREG   = 5'd8;
    localparam logic [4:0] LUMOP_FFIRST = 5'd16;

    // width field codes
    localparam logic [1:0] EW_8  = 2'd0;
    localparam logic [1:0] EW_16 = 2'd1;
    localparam logic [1:0] EW_32 = 2'd2;
    localparam logic [1:0] EW_64 = 2'd3;

    localparam logic [3:0] ILLEGAL_BYTES = 4'd1;

    // after decode
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] stride;
        logic [63:0] ioff;
        logic [11:0] idx;
        logic [12:0] evl;
        logic [1:0]  eew;
        logic [2:0]  nf_last;
        logic [4:0]  vd;
        logic [1:0]  emul_sh;
        logic        ld;
        logic        act;
        logic        bad;
        logic        fof;
        logic        indexed;
    } t_dec;

    // after offset multiply
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] offs;
        logic [11:0] idx;
        logic [1:0]  eew;
        logic [2:0]  nf_last;
        logic [4:0]  vd;
        logic [1:0]  emul_sh;
        logic        ld;
        logic        act;
        logic        bad;
        logic        fin;
    } t_mid;

    // element ready for segment expansion
    typedef struct packed {
        logic [63:0] addr0;
        logic [11:0] idx;
        logic [1:0]  eew;
        logic [2:0]  nf_last;
        logic [4:0]  vd;
        logic [1:0]  emul_sh;
        logic        ld;
        logic        act;
        logic        bad;
        logic        fin;
    } t_elem;

    // one result transaction
    typedef struct packed {
        logic [63:0] addr;
        logic [2:0]  grp;
        logic [15:0] pos;
        logic [3:0]  bytes;
        logic [2:0]  seg;
        logic        ld;
        logic        act;
        logic        illegal;
        logic        fin;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

[design/vlsag_seg_expand.sv]
// vlsag_seg_expand: walks the segments of one element and drives the result register.
// One result per cycle while the receiver is ready; releases the element when its last segment is loaded.
// Depends on vlsag_pkg.
`default_nettype none

module vlsag_seg_expand (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_elem_valid,
    input  wire vlsag_pkg::t_elem  i_elem,
    input  wire logic [9:0]        i_reg_bytes,
    output logic                   o_elem_taken,
    output logic                   o_res_valid,
    output vlsag_pkg::t_result     o_res,
    input  wire logic              i_res_ready
);

    logic [2:0]          r_seg;
    logic                r_valid;
    vlsag_pkg::t_result  r_res;
    vlsag_pkg::t_result  n_res;

    logic        out_free;
    logic        load;
    logic        seg_last;
    logic [6:0]  reg_num;
    logic [14:0] idx_sh;
    logic [12:0] lane;

    assign out_free = !r_valid || i_res_ready;
    assign load     = i_elem_valid && out_free;
    assign seg_last = (r_seg == i_elem.nf_last);
    assign o_elem_taken = load && seg_last;

    // register vd + s*emul, then the byte position inside its group of eight
    assign reg_num = 7'(i_elem.vd) + (7'(r_seg) << i_elem.emul_sh);
    assign idx_sh  = 15'(i_elem.idx) << i_elem.eew;
    assign lane    = 13'(reg_num[2:0]) * 13'(i_reg_bytes);

    always_comb begin
        if (i_elem.bad) begin
            n_res         = '0;
            n_res.bytes   = vlsag_pkg::ILLEGAL_BYTES;
            n_res.illegal = 1'b1;
            n_res.fin     = 1'b1;
            n_res.last    = 1'b1;
        end else begin
            n_res.addr    = i_elem.addr0 + (64'(r_seg) << i_elem.eew);
            n_res.grp     = reg_num[6] ? 3'd7 : reg_num[5:3];
            n_res.pos     = 16'(idx_sh) + 16'(lane);
            n_res.bytes   = 4'd1 << i_elem.eew;
            n_res.seg     = r_seg;
            n_res.ld      = i_elem.ld;
            n_res.act     = i_elem.act;
            n_res.illegal = 1'b0;
            n_res.fin     = i_elem.fin;
            n_res.last    = seg_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seg   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_seg   <= seg_last ? 3'd0 : r_seg + 3'd1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

[design/vector_load_store_address_gen_core.sv]
// Vector load/store address generator, top level.
// Usage: one element request enters on the slave stream per transaction; for each segment
// of that element one result leaves on the master stream, tlast on the element's final one.
// Illegal encodings give a single result with illegal set.
// Configuration (vl, vsew, vlmul, vlenb) is written through the plain write port. The user
// must write it only while no element is in flight; the block itself does not enforce this.
// Pipeline: an accepted request passes decode, offset multiply, base add and the result
// register before its first result. Further segments follow one per cycle while tready is high.
// An element with nf segments occupies the segment sequencer until its last segment is loaded;
// requests enter back to back while earlier ones are in the pipeline.
// Reset clears all valid bits and loads the configuration reset values (vlenb 16).
// When the receiver holds tready low the result register holds, the stages behind it
// fill, and tready on the slave side drops once every stage is occupied.
`default_nettype none

module vector_load_store_address_gen_core #(
    parameter int MAX_VLEN_BITS = 4096,
    parameter int MAX_SEGMENTS  = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [12:0]  i_cfg_data,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // instruction[31:0], base_address[95:32], stride_value[159:96],
    // element_index[171:160], mask_bit[172], index_offset[236:173], zero[239:237]
    input  wire logic [239:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // access_address[63:0], register_group[66:64], group_byte_offset[82:67],
    // access_bytes[86:83], segment_index[89:87], is_load[90], active[91],
    // illegal[92], final_element[93], zero[95:94]
    output logic [95:0]       o_m_axis_tdata,
    output logic              o_m_axis_tlast
);

    localparam int VlenbMax = MAX_VLEN_BITS / 8;

    // configuration
    logic [12:0] r_vl;
    logic [1:0]  r_sew;
    logic [2:0]  r_lmul;
    logic [9:0]  r_vlenb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl    <= '0;
            r_sew   <= '0;
            r_lmul  <= '0;
            r_vlenb <= 10'd16;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                vlsag_pkg::CFG_VECTOR_LENGTH:  r_vl    <= i_cfg_data;
                vlsag_pkg::CFG_ELEMENT_WIDTH:  r_sew   <= i_cfg_data[1:0];
                vlsag_pkg::CFG_GROUP_MULT:     r_lmul  <= i_cfg_data[2:0];
                vlsag_pkg::CFG_REGISTER_BYTES: r_vlenb <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // stage valids and handshake
    logic r_va, r_vb, r_vc;
    logic ready_a, ready_b, ready_c;
    logic c_taken;

    assign ready_c = !r_vc || c_taken;
    assign ready_b = !r_vb || ready_c;
    assign ready_a = !r_va || ready_b;
    assign o_s_axis_tready = ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ready_a) r_va <= i_s_axis_tvalid;
            if (ready_b) r_vb <= r_va;
            if (ready_c) r_vc <= r_vb;
        end
    end

    // stage a: decode
    logic [31:0] ins;
    logic [1:0]  mop;
    logic [4:0]  lumop;
    logic        unit, strided, indexed, ld, whole, fof, bad_enc;
    logic [1:0]  iw, eew;
    logic [3:0]  nf0, nf;
    logic [2:0]  vemul;
    logic [13:0] whole_bytes;
    logic [63:0] ioff_raw;
    vlsag_pkg::t_dec n_a, r_a;

    assign ins      = i_s_axis_tdata[31:0];
    assign ioff_raw = i_s_axis_tdata[236:173];
    assign mop      = ins[27:26];
    assign lumop    = ins[24:20];
    assign iw       = ins[13:12];
    assign unit     = (mop == vlsag_pkg::MOP_UNIT);
    assign strided  = (mop == vlsag_pkg::MOP_STRIDED);
    assign indexed  = !unit && !strided;
    assign ld       = !ins[5];
    assign whole    = unit && (lumop == vlsag_pkg::LUMOP_WREG);
    assign fof      = unit && (lumop == vlsag_pkg::LUMOP_FFIRST);
    assign bad_enc  = ins[28] || (unit && !((lumop == vlsag_pkg::LUMOP_PLAIN) ||
                      (lumop == vlsag_pkg::LUMOP_WREG) ||
                      (ld && (lumop == vlsag_pkg::LUMOP_FFIRST))));
    assign eew      = indexed ? r_sew : iw;
    assign nf0      = {1'b0, ins[31:29]} + 4'd1;
    assign nf       = whole ? 4'd1 : nf0;
    assign whole_bytes = 14'(nf0) * 14'(r_vlenb);
    assign vemul    = whole ? 3'd0 : (r_lmul + {1'b0, eew} - {1'b0, r_sew});

    always_comb begin
        n_a.base    = i_s_axis_tdata[95:32];
        n_a.stride  = strided ? i_s_axis_tdata[159:96] : (64'(nf) << eew);
        unique case (iw)
            vlsag_pkg::EW_8:  n_a.ioff = {56'd0, ioff_raw[7:0]};
            vlsag_pkg::EW_16: n_a.ioff = {48'd0, ioff_raw[15:0]};
            vlsag_pkg::EW_32: n_a.ioff = {32'd0, ioff_raw[31:0]};
            vlsag_pkg::EW_64: n_a.ioff = ioff_raw;
            default:          n_a.ioff = ioff_raw;
        endcase
        n_a.idx     = i_s_axis_tdata[171:160];
        n_a.evl     = whole ? 13'(whole_bytes >> eew) : r_vl;
        n_a.eew     = eew;
        n_a.bad     = bad_enc || (14'(r_vlenb) > 14'(VlenbMax)) ||
                      (5'(nf) > 5'(MAX_SEGMENTS));
        n_a.nf_last = n_a.bad ? 3'd0 : 3'(nf - 4'd1);
        n_a.vd      = ins[11:7];
        n_a.emul_sh = vemul[2] ? 2'd0 : vemul[1:0];
        n_a.ld      = ld;
        n_a.act     = ins[25] || i_s_axis_tdata[172];
        n_a.fof     = fof;
        n_a.indexed = indexed;
    end

    // stage b: offset multiply and end-of-instruction compare
    vlsag_pkg::t_mid n_b, r_b;
    logic [63:0] prod;

    assign prod = 64'(r_a.stride * 64'(r_a.idx));

    always_comb begin
        n_b.base    = r_a.base;
        n_b.offs    = r_a.indexed ? r_a.ioff : prod;
        n_b.idx     = r_a.idx;
        n_b.eew     = r_a.eew;
        n_b.nf_last = r_a.nf_last;
        n_b.vd      = r_a.vd;
        n_b.emul_sh = r_a.emul_sh;
        n_b.ld      = r_a.ld;
        n_b.act     = r_a.act;
        n_b.bad     = r_a.bad;
        n_b.fin     = r_a.fof || ((13'(r_a.idx) + 13'd1) >= r_a.evl);
    end

    // stage c: base add
    vlsag_pkg::t_elem n_c, r_c;

    always_comb begin
        n_c.addr0   = r_b.base + r_b.offs;
        n_c.idx     = r_b.idx;
        n_c.eew     = r_b.eew;
        n_c.nf_last = r_b.nf_last;
        n_c.vd      = r_b.vd;
        n_c.emul_sh = r_b.emul_sh;
        n_c.ld      = r_b.ld;
        n_c.act     = r_b.act;
        n_c.bad     = r_b.bad;
        n_c.fin     = r_b.fin;
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_s_axis_tvalid) r_a <= n_a;
        if (ready_b && r_va)            r_b <= n_b;
        if (ready_c && r_vb)            r_c <= n_c;
    end

    // segment sequencer and result register
    vlsag_pkg::t_result res;

    vlsag_seg_expand u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_valid (r_vc),
        .i_elem       (r_c),
        .i_reg_bytes  (r_vlenb),
        .o_elem_taken (c_taken),
        .o_res_valid  (o_m_axis_tvalid),
        .o_res        (res),
        .i_res_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, res.fin, res.illegal, res.act, res.ld, res.seg,
                             res.bytes, res.pos, res.grp, res.addr};
    assign o_m_axis_tlast = res.last;

endmodule

`default_nettype wire

[design/vlsag_checker.sv]
// vlsag_checker: port-level assertions for the vector load/store address generator.
// Bound to vector_load_store_address_gen_core; sees only its ports.
`default_nettype none

module vlsag_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [95:0]  o_m_axis_tdata,
    input wire logic         o_m_axis_tlast
);

    logic       out_xact;
    logic       illegal;
    logic [2:0] seg;
    logic [3:0] bytes;
    logic       fin;

    assign out_xact = o_m_axis_tvalid && i_m_axis_tready;
    assign illegal  = o_m_axis_tdata[92];
    assign seg      = o_m_axis_tdata[89:87];
    assign bytes    = o_m_axis_tdata[86:83];
    assign fin      = o_m_axis_tdata[93];

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

    // illegal encodings give a lone one-byte result that ends the instruction
    a_illegal_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && illegal) |->
            (o_m_axis_tlast && fin && (bytes == 4'd1) && (seg == 3'd0)))
        else $error("malformed illegal result");

    // segments of one element follow without gaps and in order
    a_seg_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xact && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && (seg == $past(seg) + 3'd1)))
        else $error("segment sequence broken");

endmodule

bind vector_load_store_address_gen_core vlsag_checker u_vlsag_checker (.*);

`default_nettype wire
